// ----- src/frs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the fog palette remap search block.
// No dependencies; frs_dist, the top level and the bench import it.
package frs_pkg;

	localparam int ByteW     = 8;
	localparam int ColourW   = 3 * ByteW;
	localparam int DistW     = 18;
	localparam int CfgIndexW = 2;
	localparam int OpW       = 2;
	localparam int LevelW    = 5;

	localparam logic [OpW-1:0] OpWrite   = 2'd0;
	localparam logic [OpW-1:0] OpNearest = 2'd1;
	localparam logic [OpW-1:0] OpFog     = 2'd2;

	localparam logic [CfgIndexW-1:0] CfgFogRed   = 2'd0;
	localparam logic [CfgIndexW-1:0] CfgFogGreen = 2'd1;
	localparam logic [CfgIndexW-1:0] CfgFogBlue  = 2'd2;

	localparam logic [ByteW-1:0] FogReset   = 8'd128;
	localparam logic [ByteW-1:0] ClearIndex = 8'd255;
	localparam logic [ByteW-1:0] LastSearch = 8'd254;
	localparam logic [DistW-1:0] NoDistance = '1;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] index;
		logic [DistW-1:0] distance;
	} cand_t;

endpackage

// ----- src/frs_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the query beats and the result beats.
// No dependencies.
interface frs_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] entry_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [4:0] fog_level;

	modport source (output valid, operation, entry_index, red, green, blue, fog_level,
		input ready);
	modport sink (input valid, operation, entry_index, red, green, blue, fog_level,
		output ready);
endinterface

interface frs_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  nearest_index;
	logic [17:0] nearest_distance;
	logic        exact_match;

	modport source (output valid, nearest_index, nearest_distance, exact_match,
		input ready);
	modport sink (input valid, nearest_index, nearest_distance, exact_match,
		output ready);
endinterface

// ----- src/frs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with a registered read.
// No dependencies.
module frs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/frs_dist.sv -----
`timescale 1ns / 1ps
// Two-stage squared RGB distance unit: channel squares, then their sum.
// Depends on frs_pkg.
module frs_dist (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [7:0]             in_index,
	input  logic [23:0]            entry,
	input  logic [23:0]            target,
	output frs_pkg::cand_t         cand,
	output logic                   busy
);
	import frs_pkg::*;

	logic [ByteW-1:0] dr, dg, db;
	logic [15:0]      sq_r_s2, sq_g_s2, sq_b_s2;
	logic [ByteW-1:0] idx_s2;
	logic             v_s2;
	logic             cand_v_s3;
	logic [ByteW-1:0] cand_idx_s3;
	logic [DistW-1:0] cand_dist_s3;

	function automatic logic [ByteW-1:0] abs_diff(input logic [ByteW-1:0] a,
		input logic [ByteW-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	assign dr = abs_diff(entry[23:16], target[23:16]);
	assign dg = abs_diff(entry[15:8], target[15:8]);
	assign db = abs_diff(entry[7:0], target[7:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			cand_v_s3 <= 1'b0;
		end else begin
			v_s2      <= in_valid;
			cand_v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq_r_s2      <= {8'd0, dr} * {8'd0, dr};
		sq_g_s2      <= {8'd0, dg} * {8'd0, dg};
		sq_b_s2      <= {8'd0, db} * {8'd0, db};
		idx_s2       <= in_index;
		cand_idx_s3  <= idx_s2;
		cand_dist_s3 <= DistW'(sq_r_s2) + DistW'(sq_g_s2) + DistW'(sq_b_s2);
	end

	assign cand = '{valid: cand_v_s3, index: cand_idx_s3, distance: cand_dist_s3};
	assign busy = v_s2 | cand_v_s3;

endmodule

// ----- src/fog_palette_remap_search.sv -----
`timescale 1ns / 1ps
// Channel  | Dir | Beat contents
// item     | in  | operation, entry_index, red, green, blue, fog_level
// result   | out | nearest_index, nearest_distance, exact_match
// cfg      | in  | cfg_we, cfg_index, cfg_wdata (fog colour registers)
// A nearest query makes 255 palette reads (entries 0 to 254) at one entry per cycle through the single
// RAM port, then drains the distance pipeline and registers the result; an exact match ends the scan early.
// Before its scan, a fog query does a palette read, then per channel two products and a reciprocal
// division, all on one shared multiplier.
// The palette has no reset; entries must be written before they are queried.
// Results wait in an output register; a new beat is taken once the result is registered.
// Top level of the fog palette remap search. Depends on frs_pkg, frs_if, frs_ram, frs_dist.
module fog_palette_remap_search #(
	parameter int FOG_LEVEL_COUNT = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	frs_item_if.sink                        item,
	frs_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [frs_pkg::CfgIndexW-1:0]   cfg_index,
	input  logic [frs_pkg::ByteW-1:0]       cfg_wdata
);
	import frs_pkg::*;

	localparam logic [ByteW-1:0] TOP = ByteW'(FOG_LEVEL_COUNT - 1);
	localparam int TOP_INT = FOG_LEVEL_COUNT - 1;
	localparam int RECIP_SHIFT = 16 + $clog2(TOP_INT);
	localparam logic [17:0] RECIP = 18'(((64'd1 << RECIP_SHIFT) + 64'(TOP_INT) - 64'd1)
		/ 64'(TOP_INT));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL_A,
		ST_MUL_B,
		ST_DIV,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [ByteW-1:0]  fog_r_q, fog_g_q, fog_b_q;
	logic [ByteW-1:0]  tgt_r_q, tgt_g_q, tgt_b_q;
	logic [ColourW-1:0] src_q;
	logic [ByteW-1:0]  lvl_q;
	logic [1:0]        chan_q;
	logic [15:0]       acc_q;
	logic              clear_q;
	logic [ByteW-1:0]  addr_q, last_q;
	logic              issue_done_q, found_q;
	logic              v_s1_q;
	logic [ByteW-1:0]  idx_s1_q;
	logic [DistW-1:0]  best_q;
	logic [ByteW-1:0]  best_idx_q;
	logic              out_valid_q;
	logic [ByteW-1:0]  out_index_q;
	logic [DistW-1:0]  out_dist_q;

	logic               accept;
	logic               issue;
	logic               ram_we;
	logic [ByteW-1:0]   ram_addr;
	logic [ColourW-1:0] ram_rdata;
	logic [ByteW-1:0]   lvl_in;
	logic [ByteW-1:0]   chan_p, chan_f;
	logic [15:0]        mul_a;
	logic [17:0]        mul_b;
	logic [33:0]        mul_prod;
	logic [15:0]        mul_out;
	logic [ByteW-1:0]   quo_next;
	cand_t              cand;
	logic               dist_busy;

	assign accept = item.valid & item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign issue = (state_q == ST_SCAN) & ~issue_done_q & ~found_q;
	assign ram_we = accept & (item.operation == OpWrite);
	assign ram_addr = (state_q == ST_IDLE) ? item.entry_index : addr_q;
	assign lvl_in = ({3'b000, item.fog_level} > TOP) ? TOP : {3'b000, item.fog_level};

	always_comb begin
		case (chan_q)
			2'd0: begin
				chan_p = src_q[23:16];
				chan_f = fog_r_q;
			end
			2'd1: begin
				chan_p = src_q[15:8];
				chan_f = fog_g_q;
			end
			default: begin
				chan_p = src_q[7:0];
				chan_f = fog_b_q;
			end
		endcase
	end

	assign mul_a = (state_q == ST_DIV) ? acc_q :
		{8'd0, (state_q == ST_MUL_A) ? chan_p : chan_f};
	assign mul_b = (state_q == ST_DIV) ? RECIP :
		{10'd0, (state_q == ST_MUL_A) ? TOP - lvl_q : lvl_q};
	assign mul_prod = {18'd0, mul_a} * {16'd0, mul_b};
	assign mul_out = mul_prod[15:0];
	assign quo_next = mul_prod[RECIP_SHIFT +: ByteW];

	frs_ram #(
		.WIDTH (ColourW),
		.DEPTH (256)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({item.red, item.green, item.blue}),
		.rdata (ram_rdata)
	);

	frs_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1_q),
		.in_index (idx_s1_q),
		.entry    (ram_rdata),
		.target   ({tgt_r_q, tgt_g_q, tgt_b_q}),
		.cand     (cand),
		.busy     (dist_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fog_r_q <= FogReset;
			fog_g_q <= FogReset;
			fog_b_q <= FogReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgFogRed:   fog_r_q <= cfg_wdata;
				CfgFogGreen: fog_g_q <= cfg_wdata;
				CfgFogBlue:  fog_b_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tgt_r_q      <= '0;
			tgt_g_q      <= '0;
			tgt_b_q      <= '0;
			src_q        <= '0;
			lvl_q        <= '0;
			chan_q       <= '0;
			acc_q        <= '0;
			clear_q      <= 1'b0;
			addr_q       <= '0;
			last_q       <= '0;
			issue_done_q <= 1'b0;
			found_q      <= 1'b0;
			v_s1_q       <= 1'b0;
			idx_s1_q     <= '0;
			best_q       <= NoDistance;
			best_idx_q   <= '0;
			out_valid_q  <= 1'b0;
			out_index_q  <= '0;
			out_dist_q   <= '0;
		end else begin
			v_s1_q   <= issue;
			idx_s1_q <= addr_q;
			if (issue) begin
				if (addr_q == last_q) begin
					issue_done_q <= 1'b1;
				end else begin
					addr_q <= addr_q + 8'd1;
				end
			end
			if (cand.valid && !found_q && cand.distance < best_q) begin
				best_q     <= cand.distance;
				best_idx_q <= cand.index;
				found_q    <= (cand.distance == '0);
			end
			if (result.ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					addr_q       <= '0;
					last_q       <= LastSearch;
					issue_done_q <= 1'b0;
					found_q      <= 1'b0;
					best_q       <= NoDistance;
					best_idx_q   <= '0;
					clear_q      <= (item.entry_index == ClearIndex);
					lvl_q        <= lvl_in;
					chan_q       <= '0;
					if (accept && item.operation == OpNearest) begin
						tgt_r_q <= item.red;
						tgt_g_q <= item.green;
						tgt_b_q <= item.blue;
						state_q <= ST_SCAN;
					end else if (accept && item.operation == OpFog) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					src_q   <= ram_rdata;
					state_q <= ST_MUL_A;
				end
				ST_MUL_A: begin
					acc_q   <= mul_out;
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					acc_q   <= acc_q + mul_out;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					case (chan_q)
						2'd0:    tgt_r_q <= quo_next;
						2'd1:    tgt_g_q <= quo_next;
						default: tgt_b_q <= quo_next;
					endcase
					if (chan_q == 2'd2) begin
						if (clear_q) begin
							addr_q <= ClearIndex;
							last_q <= ClearIndex;
						end
						state_q <= ST_SCAN;
					end else begin
						chan_q  <= chan_q + 2'd1;
						state_q <= ST_MUL_A;
					end
				end
				ST_SCAN: begin
					if ((issue_done_q || found_q) && !v_s1_q && !dist_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_index_q <= best_idx_q;
						out_dist_q  <= best_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid            = out_valid_q;
	assign result.nearest_index    = out_index_q;
	assign result.nearest_distance = out_dist_q;
	assign result.exact_match      = (out_dist_q == '0);

`ifndef SYNTH
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> (!v_s1_q && !dist_busy))
		else $error("Search pipeline still busy while a new beat can be taken.");

	a_found_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_q == '0))
		else $error("Exact match flagged with a non-zero best distance.");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_FINISH))
		else $error("Result beat raised outside the finish step.");

	a_no_issue_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && issue_done_q) |=> !issue)
		else $error("Palette read issued after the last scan address.");
`endif

endmodule

// ----- test/fog_palette_remap_search_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for fog_palette_remap_search: fills the palette, runs a directed
// table and then random query beats under four idling modes, checking against a predictor.
// Depends on frs_pkg, frs_if and the block's RTL; nothing else.
module fog_palette_remap_search_test;
	import frs_pkg::*;

	localparam int FogLevels = 32;
	localparam int TopLevel = FogLevels - 1;
	localparam logic [OpW-1:0] OpUnused = 2'd3;
	localparam int unsigned NoMatchDistance = 32'h7FFF_FFFF;
	localparam int SettleCycles = 320;
	localparam int ItemsPerPhase = 100;
	localparam int PhaseCount = 4;
	localparam int DirectedCount = 22;

	typedef struct packed {
		logic [OpW-1:0]    op;
		logic [ByteW-1:0]  entry;
		logic [ByteW-1:0]  red;
		logic [ByteW-1:0]  green;
		logic [ByteW-1:0]  blue;
		logic [LevelW-1:0] level;
	} query_t;

	typedef struct packed {
		logic [ByteW-1:0] index;
		logic [DistW-1:0] distance;
		logic             exact;
	} match_t;

	typedef struct packed {
		query_t q;
		logic   typed;
		match_t want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [ByteW-1:0] cfg_wdata;

	frs_item_if item_ch ();
	frs_result_if result_ch ();

	fog_palette_remap_search #(.FOG_LEVEL_COUNT(FogLevels)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [ByteW-1:0] pal_red [256];
	logic [ByteW-1:0] pal_green [256];
	logic [ByteW-1:0] pal_blue [256];
	logic [ByteW-1:0] fog_red = FogReset;
	logic [ByteW-1:0] fog_green = FogReset;
	logic [ByteW-1:0] fog_blue = FogReset;

	match_t expected_matches [$];
	int mismatch_count = 0;
	int sender_idle_pct = 0;
	int result_stall_pct = 0;

	directed_row_t directed_rows [DirectedCount] = '{
		'{'{OpNearest, 8'd0, 8'd255, 8'd255, 8'd255, 5'd0}, 1'b1, '{8'd0, 18'd195075, 1'b0}},
		'{'{OpNearest, 8'd0, 8'd0, 8'd0, 8'd0, 5'd0}, 1'b1, '{8'd0, 18'd0, 1'b1}},
		'{'{OpFog, 8'd255, 8'd0, 8'd0, 8'd0, 5'd0}, 1'b1, '{8'd255, 18'd0, 1'b1}},
		'{'{OpFog, 8'd255, 8'd0, 8'd0, 8'd0, 5'd31}, 1'b1, '{8'd255, 18'd49152, 1'b0}},
		'{'{OpFog, 8'd0, 8'd0, 8'd0, 8'd0, 5'd31}, 1'b1, '{8'd0, 18'd49152, 1'b0}},
		'{'{OpWrite, 8'd254, 8'd255, 8'd255, 8'd255, 5'd0}, 1'b0, '0},
		'{'{OpWrite, 8'd255, 8'd255, 8'd0, 8'd0, 5'd0}, 1'b0, '0},
		'{'{OpNearest, 8'd0, 8'd255, 8'd255, 8'd255, 5'd0}, 1'b1, '{8'd254, 18'd0, 1'b1}},
		'{'{OpNearest, 8'd0, 8'd255, 8'd0, 8'd0, 5'd0}, 1'b1, '{8'd0, 18'd65025, 1'b0}},
		'{'{OpWrite, 8'd7, 8'd10, 8'd20, 8'd30, 5'd0}, 1'b0, '0},
		'{'{OpWrite, 8'd9, 8'd10, 8'd20, 8'd30, 5'd0}, 1'b0, '0},
		'{'{OpNearest, 8'd0, 8'd11, 8'd20, 8'd30, 5'd0}, 1'b0, '0},
		'{'{OpNearest, 8'd0, 8'd10, 8'd20, 8'd30, 5'd0}, 1'b1, '{8'd7, 18'd0, 1'b1}},
		'{'{OpFog, 8'd254, 8'd0, 8'd0, 8'd0, 5'd31}, 1'b0, '0},
		'{'{OpFog, 8'd254, 8'd0, 8'd0, 8'd0, 5'd16}, 1'b0, '0},
		'{'{OpFog, 8'd7, 8'd0, 8'd0, 8'd0, 5'd0}, 1'b1, '{8'd7, 18'd0, 1'b1}},
		'{'{OpUnused, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'h1F}, 1'b0, '0},
		'{'{OpWrite, 8'd0, 8'd128, 8'd128, 8'd128, 5'd0}, 1'b0, '0},
		'{'{OpFog, 8'd100, 8'd0, 8'd0, 8'd0, 5'd31}, 1'b1, '{8'd0, 18'd0, 1'b1}},
		'{'{OpFog, 8'd255, 8'd0, 8'd0, 8'd0, 5'd15}, 1'b0, '0},
		'{'{OpNearest, 8'd0, 8'd254, 8'd1, 8'd0, 5'd0}, 1'b0, '0},
		'{'{OpWrite, 8'd255, 8'd0, 8'd0, 8'd0, 5'd0}, 1'b0, '0}
	};

	function automatic int unsigned colour_distance(input int idx, input int r, input int g,
		input int b);
		int dr;
		int dg;
		int db;
		dr = r - int'(pal_red[idx]);
		dg = g - int'(pal_green[idx]);
		db = b - int'(pal_blue[idx]);
		return dr * dr + dg * dg + db * db;
	endfunction

	function automatic match_t nearest_entry(input int r, input int g, input int b);
		int unsigned best_d;
		int unsigned d;
		int best;
		match_t m;
		best_d = NoMatchDistance;
		best = 0;
		for (int i = 0; i <= int'(LastSearch); i++) begin
			d = colour_distance(i, r, g, b);
			if (d < best_d) begin
				best_d = d;
				best = i;
				if (d == 0)
					break;
			end
		end
		m.index = ByteW'(best);
		m.distance = DistW'(best_d);
		m.exact = (best_d == 0);
		return m;
	endfunction

	function automatic int blend_channel(input int p, input int f, input int lv);
		return (p * (TopLevel - lv) + f * lv) / TopLevel;
	endfunction

	function automatic bit predict_remap(input query_t q, output match_t m);
		int lv;
		int tr;
		int tg;
		int tb;
		int unsigned d;
		m = '0;
		case (q.op)
			OpWrite: begin
				pal_red[q.entry] = q.red;
				pal_green[q.entry] = q.green;
				pal_blue[q.entry] = q.blue;
				return 1'b0;
			end
			OpNearest: begin
				m = nearest_entry(q.red, q.green, q.blue);
			end
			OpFog: begin
				lv = (int'(q.level) > TopLevel) ? TopLevel : int'(q.level);
				tr = blend_channel(pal_red[q.entry], fog_red, lv);
				tg = blend_channel(pal_green[q.entry], fog_green, lv);
				tb = blend_channel(pal_blue[q.entry], fog_blue, lv);
				if (q.entry == ClearIndex) begin
					d = colour_distance(ClearIndex, tr, tg, tb);
					m.index = ClearIndex;
					m.distance = DistW'(d);
					m.exact = (d == 0);
				end else begin
					m = nearest_entry(tr, tg, tb);
				end
			end
			default: begin
				return 1'b0;
			end
		endcase
		return 1'b1;
	endfunction

	function automatic logic [ByteW-1:0] near_byte(input logic [ByteW-1:0] v);
		int x;
		x = int'(v) + int'($urandom_range(8)) - 4;
		if (x < 0)
			x = 0;
		if (x > 255)
			x = 255;
		return ByteW'(x);
	endfunction

	function automatic query_t make_random_query();
		query_t q;
		int pick;
		int src;
		q.op = OpWrite;
		q.entry = ByteW'($urandom_range(255));
		q.red = ByteW'($urandom_range(255));
		q.green = ByteW'($urandom_range(255));
		q.blue = ByteW'($urandom_range(255));
		q.level = LevelW'($urandom_range(TopLevel));
		pick = $urandom_range(99);
		src = $urandom_range(255);
		if (pick < 35) begin
			case ($urandom_range(7))
				0: {q.red, q.green, q.blue} = '0;
				1: {q.red, q.green, q.blue} = '1;
				2, 3: {q.red, q.green, q.blue} = {pal_red[src], pal_green[src], pal_blue[src]};
				default: ;
			endcase
		end else if (pick < 60) begin
			q.op = OpNearest;
			case ($urandom_range(9))
				0, 1, 2, 3: {q.red, q.green, q.blue} = {pal_red[src], pal_green[src],
					pal_blue[src]};
				4, 5, 6: begin
					q.red = near_byte(pal_red[src]);
					q.green = near_byte(pal_green[src]);
					q.blue = near_byte(pal_blue[src]);
				end
				default: ;
			endcase
		end else if (pick < 95) begin
			q.op = OpFog;
			if ($urandom_range(9) == 0)
				q.entry = ClearIndex;
			case ($urandom_range(4))
				0: q.level = '0;
				1: q.level = LevelW'(TopLevel);
				default: ;
			endcase
		end else begin
			q.op = OpUnused;
		end
		return q;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_result();
		match_t want;
		if (expected_matches.size() == 0) begin
			report_mismatch("result beat with nothing expected, index",
				result_ch.nearest_index, -1);
		end else begin
			want = expected_matches.pop_front();
			if (result_ch.nearest_index !== want.index)
				report_mismatch("nearest_index", result_ch.nearest_index, want.index);
			if (result_ch.nearest_distance !== want.distance)
				report_mismatch("nearest_distance", result_ch.nearest_distance, want.distance);
			if (result_ch.exact_match !== want.exact)
				report_mismatch("exact_match", result_ch.exact_match, want.exact);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready)
				check_result();
			result_ch.ready <= ($urandom_range(99) >= result_stall_pct);
		end
	end

	task automatic send_query(input query_t q, input bit use_typed, input match_t typed);
		match_t m;
		while ($urandom_range(99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= q.op;
		item_ch.entry_index <= q.entry;
		item_ch.red <= q.red;
		item_ch.green <= q.green;
		item_ch.blue <= q.blue;
		item_ch.fog_level <= q.level;
		do
			@(posedge clk);
		while (!item_ch.ready);
		if (predict_remap(q, m))
			expected_matches.push_back(use_typed ? typed : m);
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (expected_matches.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_fog(input logic [ByteW-1:0] r, input logic [ByteW-1:0] g,
		input logic [ByteW-1:0] b);
		cfg_we <= 1'b1;
		cfg_index <= CfgFogRed;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_index <= CfgFogGreen;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_index <= CfgFogBlue;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		fog_red = r;
		fog_green = g;
		fog_blue = b;
	endtask

	initial begin
		#(64'd40_000_000);
		$display("status: fail");
		$finish;
	end

	initial begin
		query_t q;
		int sent;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CfgFogRed;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.operation <= OpWrite;
		item_ch.entry_index <= '0;
		item_ch.red <= '0;
		item_ch.green <= '0;
		item_ch.blue <= '0;
		item_ch.fog_level <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every entry is loaded black first so that no query ever reads an unwritten entry.
		for (int e = 0; e < 256; e++)
			send_query('{OpWrite, ByteW'(e), 8'd0, 8'd0, 8'd0, 5'd0}, 1'b0, '0);
		for (int i = 0; i < DirectedCount; i++)
			send_query(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < PhaseCount; p++) begin
			drain_results();
			sender_idle_pct = (p == 1) ? 50 : (p == 3) ? 28 : 0;
			result_stall_pct = (p == 2) ? 50 : (p == 3) ? 28 : 0;
			case (p)
				0: write_fog(8'd0, 8'd0, 8'd0);
				1: write_fog(8'd255, 8'd255, 8'd255);
				2: write_fog(8'd255, 8'd0, 8'd128);
				default: write_fog(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
					ByteW'($urandom_range(255)));
			endcase
			sent = 0;
			while (sent < ItemsPerPhase) begin
				q = make_random_query();
				send_query(q, 1'b0, '0);
				if (q.op != OpUnused)
					sent++;
			end
		end
		drain_results();

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
